### rtl/sprite_blitter_clip_colorkey_defines.svh
// assertion macros for the sprite blitter
// used by files that assert; needs i_clk and i_rst_n in scope
`ifndef SPRITE_BLITTER_CLIP_COLORKEY_DEFINES_SVH
`define SPRITE_BLITTER_CLIP_COLORKEY_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SBCC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SBCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sbcc_pkg.sv
// types and constants shared by the sprite blitter files
// no dependencies
package sbcc_pkg;

    localparam int TILE_PIXELS = 8;
    localparam int TILE_SHIFT  = 3;
    // coordinate width: 16-bit position minus 16-bit camera plus sprite size
    localparam int CW = 18;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_DRAW  = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    localparam logic REG_CAMERA_X = 1'b0;
    localparam logic REG_CAMERA_Y = 1'b1;

    typedef struct packed {
        logic [1:0]         func;
        logic [13:0]        index;
        logic [7:0]         pixel;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [2:0]         width_tiles;
        logic [2:0]         height_tiles;
        logic [10:0]        sprite_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_pixel;
        logic [1:0] done_func;
    } t_out_item;

    // request to the shared coordinate adder
    typedef struct packed {
        logic               sub;
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
    } t_alu_req;

endpackage

### rtl/sbcc_alu.sv
// shared add/subtract unit for the draw setup sequence
// depends on sbcc_pkg
module sbcc_alu import sbcc_pkg::*; (
    input  t_alu_req             i_req,
    output logic signed [CW-1:0] o_sum
);

    logic [CW-1:0] b_op;

    // two's complement subtract via inverted operand and carry in
    assign b_op  = i_req.sub ? ~i_req.b : i_req.b;
    assign o_sum = i_req.a + b_op + {{(CW-1){1'b0}}, i_req.sub};

endmodule

### rtl/sprite_blitter_clip_colorkey.sv
// sprite blitter top level: sequencer, frame and sprite stores, config port
// depends on sbcc_pkg, sbcc_alu and sprite_blitter_clip_colorkey_defines.svh
//
// Usage:
//   Input beats carry one operation each (clear, load sprite pixel, draw
//   sprite, read frame pixel); each produces exactly one output beat with
//   the read pixel (zero unless a read) and the echoed function code.
//   A beat is taken when i_in_valid is high and o_in_stall is low; the block
//   stalls its input until the result is loaded, so it takes no new beat
//   while one is in flight. A clear sweeps one frame pixel a cycle; a draw
//   walks one sprite pixel a cycle through the walk counters over the clip
//   window, and skips the walk when the sprite is clipped away.
//   Draw setup: offset and edges through one shared adder, clip, sprite
//   column and row through the same adder, then a row base multiply and
//   an offset add before the pixel walk. After reset the frame store is
//   cleared while the input stalls; config writes are taken meanwhile.
//   The result sits in an output register; a new beat is accepted while it
//   waits, and the next result holds back until the receiver takes it.
//   Camera registers live at byte address 0 (x) and 4 (y); pready is high.
`include "sprite_blitter_clip_colorkey_defines.svh"
module sprite_blitter_clip_colorkey import sbcc_pkg::*; #(
    parameter int SCREEN_W  = 128,
    parameter int SCREEN_H  = 128,
    parameter int MAX_TILES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FRAME_SIZE   = SCREEN_W * SCREEN_H;
    localparam int FA           = $clog2(FRAME_SIZE);
    localparam int SPRITE_SIDE  = MAX_TILES * TILE_PIXELS;
    localparam int SPRITE_DEPTH = SPRITE_SIDE * SPRITE_SIDE;
    localparam int SA           = $clog2(SPRITE_DEPTH);
    localparam int PW_W         = $clog2(SPRITE_SIDE + 1);
    localparam int TW           = $clog2(MAX_TILES + 1);
    localparam int XW           = $clog2(SCREEN_W + 1);
    localparam int YW           = $clog2(SCREEN_H + 1);

    localparam logic [FA-1:0]        FA_LAST = FA'(FRAME_SIZE - 1);
    localparam logic signed [CW-1:0] SW_C    = CW'(SCREEN_W);
    localparam logic signed [CW-1:0] SH_C    = CW'(SCREEN_H);

    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_CLEAR = 4'd2;
    localparam logic [3:0] ST_READ  = 4'd3;
    localparam logic [3:0] ST_X0    = 4'd4;
    localparam logic [3:0] ST_Y0    = 4'd5;
    localparam logic [3:0] ST_XE    = 4'd6;
    localparam logic [3:0] ST_YE    = 4'd7;
    localparam logic [3:0] ST_CLIP  = 4'd8;
    localparam logic [3:0] ST_SC    = 4'd9;
    localparam logic [3:0] ST_SR    = 4'd10;
    localparam logic [3:0] ST_BASE  = 4'd11;
    localparam logic [3:0] ST_OFFS  = 4'd12;
    localparam logic [3:0] ST_WALK  = 4'd13;
    localparam logic [3:0] ST_DRAIN = 4'd14;
    localparam logic [3:0] ST_FIN   = 4'd15;

    // sequencer state and counters
    logic [3:0]           r_state, n_state;
    logic [FA-1:0]        r_fa, n_fa;
    logic [FA-1:0]        r_row_fa, n_row_fa;
    logic [SA-1:0]        r_si, n_si;
    logic [SA-1:0]        r_row_si, n_row_si;
    logic signed [CW-1:0] r_x0, n_x0;
    logic signed [CW-1:0] r_y0, n_y0;
    logic signed [CW-1:0] r_xend, n_xend;
    logic signed [CW-1:0] r_yend, n_yend;
    logic [XW-1:0]        r_xs, n_xs;
    logic [XW-1:0]        r_xe, n_xe;
    logic [XW-1:0]        r_x, n_x;
    logic [YW-1:0]        r_ye, n_ye;
    logic [YW-1:0]        r_y, n_y;
    logic [PW_W-1:0]      r_sc, n_sc;
    logic [PW_W-1:0]      r_sr, n_sr;
    logic                 r_p_valid, n_p_valid;
    logic                 r_out_valid, n_out_valid;

    // latched beat fields
    logic [1:0]           r_func;
    logic                 r_rd_ok;
    logic signed [15:0]   r_pos_x;
    logic signed [15:0]   r_pos_y;
    logic [PW_W-1:0]      r_pw;
    logic [PW_W-1:0]      r_ph;
    logic [10:0]          r_len;
    logic [FA-1:0]        r_p_fa;
    t_out_item            r_out_data;

    // config registers
    logic signed [15:0]   r_cam_x;
    logic signed [15:0]   r_cam_y;

    // stores
    logic [7:0]           r_frame_mem [FRAME_SIZE];
    logic [7:0]           r_sprite_mem [SPRITE_DEPTH];
    logic [7:0]           r_frame_q;
    logic [7:0]           r_sprite_q;

    logic                 in_acc;
    logic                 out_free;
    logic                 cfg_we;
    logic                 clearing;
    logic                 fr_we;
    logic [FA-1:0]        fr_waddr;
    logic [7:0]           fr_wdata;
    logic                 sp_we;
    logic [TW-1:0]        wt_sat;
    logic [TW-1:0]        ht_sat;
    logic signed [CW-1:0] xs_c, xe_c, ys_c, ye_c;
    logic                 clip_empty;
    logic [SA-1:0]        row_prod;
    logic [FA-1:0]        fa_prod;
    t_alu_req             alu_req;
    logic signed [CW-1:0] alu_sum;

    // handshakes
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // config port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_CAMERA_Y) ? {{16{r_cam_y[15]}}, r_cam_y}
                                               : {{16{r_cam_x[15]}}, r_cam_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
        end else if (cfg_we) begin
            if (paddr[2] == REG_CAMERA_X) begin
                r_cam_x <= pwdata[15:0];
            end else begin
                r_cam_y <= pwdata[15:0];
            end
        end
    end

    // tile counts saturate at the sprite store side
    assign wt_sat = (32'(i_in_data.width_tiles) > MAX_TILES) ? TW'(MAX_TILES)
                                                             : TW'(i_in_data.width_tiles);
    assign ht_sat = (32'(i_in_data.height_tiles) > MAX_TILES) ? TW'(MAX_TILES)
                                                              : TW'(i_in_data.height_tiles);

    // latch the accepted beat
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func  <= i_in_data.func;
            r_rd_ok <= (32'(i_in_data.index) < FRAME_SIZE);
            r_pos_x <= i_in_data.pos_x;
            r_pos_y <= i_in_data.pos_y;
            r_pw    <= PW_W'(wt_sat) << TILE_SHIFT;
            r_ph    <= PW_W'(ht_sat) << TILE_SHIFT;
            r_len   <= i_in_data.sprite_length;
        end
    end

    sbcc_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    // clip window against the screen
    assign xs_c       = (r_x0 < 0) ? '0 : r_x0;
    assign ys_c       = (r_y0 < 0) ? '0 : r_y0;
    assign xe_c       = (r_xend < SW_C) ? r_xend : SW_C;
    assign ye_c       = (r_yend < SH_C) ? r_yend : SH_C;
    assign clip_empty = (xs_c >= xe_c) || (ys_c >= ye_c);

    // row base products for the first visible row
    assign row_prod = SA'(r_sr) * SA'(r_pw);
    assign fa_prod  = FA'(r_y) * FA'(SCREEN_W);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_fa        = r_fa;
        n_row_fa    = r_row_fa;
        n_si        = r_si;
        n_row_si    = r_row_si;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_xend      = r_xend;
        n_yend      = r_yend;
        n_xs        = r_xs;
        n_xe        = r_xe;
        n_x         = r_x;
        n_ye        = r_ye;
        n_y         = r_y;
        n_sc        = r_sc;
        n_sr        = r_sr;
        n_p_valid   = (r_state == ST_WALK) && (32'(r_si) < 32'(r_len));
        n_out_valid = r_out_valid && i_out_stall;
        alu_req     = '{sub: 1'b0, a: '0, b: '0};
        case (r_state)
            ST_INIT, ST_CLEAR: begin
                n_fa = r_fa + FA'(1);
                if (r_fa == FA_LAST) begin
                    n_fa    = '0;
                    n_state = (r_state == ST_INIT) ? ST_IDLE : ST_FIN;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.func)
                        FUNC_CLEAR: begin
                            n_fa    = '0;
                            n_state = ST_CLEAR;
                        end
                        FUNC_LOAD: n_state = ST_FIN;
                        FUNC_DRAW: n_state = ST_X0;
                        FUNC_READ: begin
                            n_fa    = FA'(i_in_data.index);
                            n_state = ST_READ;
                        end
                        default: n_state = ST_FIN;
                    endcase
                end
            end
            ST_READ: n_state = ST_FIN;
            ST_X0: begin
                alu_req = '{sub: 1'b1, a: CW'(r_pos_x), b: CW'(r_cam_x)};
                n_x0    = alu_sum;
                n_state = ST_Y0;
            end
            ST_Y0: begin
                alu_req = '{sub: 1'b1, a: CW'(r_pos_y), b: CW'(r_cam_y)};
                n_y0    = alu_sum;
                n_state = ST_XE;
            end
            ST_XE: begin
                alu_req = '{sub: 1'b0, a: r_x0, b: CW'(r_pw)};
                n_xend  = alu_sum;
                n_state = ST_YE;
            end
            ST_YE: begin
                alu_req = '{sub: 1'b0, a: r_y0, b: CW'(r_ph)};
                n_yend  = alu_sum;
                n_state = ST_CLIP;
            end
            ST_CLIP: begin
                if (clip_empty) begin
                    n_state = ST_FIN;
                end else begin
                    n_xs    = XW'(xs_c);
                    n_xe    = XW'(xe_c);
                    n_x     = XW'(xs_c);
                    n_y     = YW'(ys_c);
                    n_ye    = YW'(ye_c);
                    n_state = ST_SC;
                end
            end
            ST_SC: begin
                // first visible sprite column
                alu_req = '{sub: 1'b1, a: CW'(r_xs), b: r_x0};
                n_sc    = PW_W'(alu_sum);
                n_state = ST_SR;
            end
            ST_SR: begin
                // first visible sprite row
                alu_req = '{sub: 1'b1, a: CW'(r_y), b: r_y0};
                n_sr    = PW_W'(alu_sum);
                n_state = ST_BASE;
            end
            ST_BASE: begin
                n_row_si = row_prod;
                n_row_fa = fa_prod;
                n_state  = ST_OFFS;
            end
            ST_OFFS: begin
                n_row_si = r_row_si + SA'(r_sc);
                n_si     = r_row_si + SA'(r_sc);
                n_row_fa = r_row_fa + FA'(r_xs);
                n_fa     = r_row_fa + FA'(r_xs);
                n_state  = ST_WALK;
            end
            ST_WALK: begin
                // one sprite pixel a cycle, row-major over the clip window
                if (r_x + XW'(1) < r_xe) begin
                    n_x  = r_x + XW'(1);
                    n_si = r_si + SA'(1);
                    n_fa = r_fa + FA'(1);
                end else if (r_y + YW'(1) < r_ye) begin
                    n_y      = r_y + YW'(1);
                    n_x      = r_xs;
                    n_row_si = r_row_si + SA'(r_pw);
                    n_si     = r_row_si + SA'(r_pw);
                    n_row_fa = r_row_fa + FA'(SCREEN_W);
                    n_fa     = r_row_fa + FA'(SCREEN_W);
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_fa        <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fa        <= n_fa;
            r_p_valid   <= n_p_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_fa <= n_row_fa;
        r_si     <= n_si;
        r_row_si <= n_row_si;
        r_x0     <= n_x0;
        r_y0     <= n_y0;
        r_xend   <= n_xend;
        r_yend   <= n_yend;
        r_xs     <= n_xs;
        r_xe     <= n_xe;
        r_x      <= n_x;
        r_ye     <= n_ye;
        r_y      <= n_y;
        r_sc     <= n_sc;
        r_sr     <= n_sr;
        r_p_fa   <= r_fa;
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            r_out_data.read_pixel <= (r_func == FUNC_READ && r_rd_ok) ? r_frame_q : 8'd0;
            r_out_data.done_func  <= r_func;
        end
    end

    // frame store: clear sweep or color-keyed sprite write
    assign clearing = (r_state == ST_INIT) || (r_state == ST_CLEAR);
    assign fr_we    = clearing || (r_p_valid && (r_sprite_q != 8'd0));
    assign fr_waddr = clearing ? r_fa : r_p_fa;
    assign fr_wdata = clearing ? 8'd0 : r_sprite_q;

    always_ff @(posedge i_clk) begin
        if (fr_we) begin
            r_frame_mem[fr_waddr] <= fr_wdata;
        end
        if (r_state == ST_READ) begin
            r_frame_q <= r_frame_mem[r_fa];
        end
    end

    // sprite store: loads in range, reads during the walk
    assign sp_we = in_acc && (i_in_data.func == FUNC_LOAD) &&
                   (32'(i_in_data.index) < SPRITE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (sp_we) begin
            r_sprite_mem[SA'(i_in_data.index)] <= i_in_data.pixel;
        end
        if (r_state == ST_WALK) begin
            r_sprite_q <= r_sprite_mem[r_si];
        end
    end

    // checks
    `SBCC_ASSERT_IMPL(a_no_write_idle, r_state == ST_IDLE, !fr_we, "frame written while idle")
    `SBCC_ASSERT_IMPL(a_walk_in_window, r_state == ST_WALK, (r_x < r_xe) && (r_y < r_ye), "walk left clip window")
    `SBCC_ASSERT_NEXT(a_pipe_from_walk, r_state != ST_WALK, !r_p_valid, "sprite beat outside walk")
    `SBCC_ASSERT_NEXT(a_accept_busy, in_acc, r_state != ST_IDLE, "accepted beat not started")

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the sprite blitter with clipping and color key
// depends on sbcc_pkg and sprite_blitter_clip_colorkey; holds its own model of both stores
`timescale 1ns / 1ps

module testbench;
    import sbcc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int SCREEN_W     = 128;
    localparam int SCREEN_H     = 128;
    localparam int MAX_TILES    = 4;
    localparam int FRAME_PIXELS = SCREEN_W * SCREEN_H;
    localparam int SPRITE_DEPTH = MAX_TILES * TILE_PIXELS * MAX_TILES * TILE_PIXELS;
    localparam int IDLE_PCT     = 6;
    localparam int PHASE_OPS    = 110;
    localparam int NUM_PHASES   = 5;
    localparam int DRAIN_CYCLES = 50;
    localparam int PRINT_CAP    = 100;
    localparam int NO_WANT      = -1;
    localparam int IN_BITS      = $bits(t_in_item);

    localparam logic [2:0] CAM_X_ADDR = {REG_CAMERA_X, 2'b00};
    localparam logic [2:0] CAM_Y_ADDR = {REG_CAMERA_Y, 2'b00};

    typedef struct {
        t_in_item op;
        int       want;
    } t_dir_row;

    // dut ports; the inputs are known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the blitter state
    bit [7:0]    frame_mem  [FRAME_PIXELS];
    bit [7:0]    sprite_mem [SPRITE_DEPTH];
    bit          sprite_set [SPRITE_DEPTH];
    int          sprite_prefix = 0;
    int          cam_x = 0;
    int          cam_y = 0;

    t_out_item   due_beats [$];
    t_in_item    op_plan [$];
    t_dir_row    dir_rows [$];
    int          op_count [4];
    int          mismatches = 0;
    int          clears_left = 8;
    bit          quiet = 1'b0;

    sprite_blitter_clip_colorkey #(
        .SCREEN_W  (SCREEN_W),
        .SCREEN_H  (SCREEN_H),
        .MAX_TILES (MAX_TILES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP) $display("tb: MISMATCH at %0t: %s", $realtime, what);
    endtask

    // walk the visible part of a draw; paint when commit is set,
    // and tell whether any never-loaded sprite entry gets read
    function automatic bit walk_draw(input t_in_item op, input bit commit);
        int x0, y0, pw, ph, len, xlo, xhi, ylo, yhi, x, y, si;
        bit hits_blank;
        x0  = int'($signed(op.pos_x)) - cam_x;
        y0  = int'($signed(op.pos_y)) - cam_y;
        pw  = ((op.width_tiles > MAX_TILES) ? MAX_TILES : int'(op.width_tiles)) * TILE_PIXELS;
        ph  = ((op.height_tiles > MAX_TILES) ? MAX_TILES : int'(op.height_tiles)) * TILE_PIXELS;
        len = (op.sprite_length > SPRITE_DEPTH) ? SPRITE_DEPTH : int'(op.sprite_length);
        xlo = (x0 > 0) ? x0 : 0;
        ylo = (y0 > 0) ? y0 : 0;
        xhi = (x0 + pw < SCREEN_W) ? x0 + pw : SCREEN_W;
        yhi = (y0 + ph < SCREEN_H) ? y0 + ph : SCREEN_H;
        hits_blank = 1'b0;
        for (y = ylo; y < yhi; y++) begin
            for (x = xlo; x < xhi; x++) begin
                si = (y - y0) * pw + (x - x0);
                if (si >= 0 && si < len) begin
                    // zero is the color key: frame keeps its pixel
                    if (!sprite_set[si]) hits_blank = 1'b1;
                    else if (commit && sprite_mem[si] != 8'd0)
                        frame_mem[y * SCREEN_W + x] = sprite_mem[si];
                end
            end
        end
        return hits_blank;
    endfunction

    // apply one operation to the shadow state and return the beat it owes
    function automatic t_out_item predict_op(input t_in_item op);
        t_out_item r;
        r.read_pixel = 8'd0;
        r.done_func  = op.func;
        case (op.func)
            FUNC_CLEAR: begin
                foreach (frame_mem[i]) frame_mem[i] = 8'd0;
            end
            FUNC_LOAD: begin
                // indices past the sprite store are dropped
                if (op.index < SPRITE_DEPTH) begin
                    sprite_mem[op.index] = op.pixel;
                    sprite_set[op.index] = 1'b1;
                    while (sprite_prefix < SPRITE_DEPTH && sprite_set[sprite_prefix])
                        sprite_prefix++;
                end
            end
            FUNC_DRAW: begin
                void'(walk_draw(op, 1'b1));
            end
            default: begin
                if (op.index < FRAME_PIXELS) r.read_pixel = frame_mem[op.index];
            end
        endcase
        return r;
    endfunction

    function automatic t_in_item mk_op(input logic [1:0] f, input int idx, input int pix,
                                       input int px, input int py, input int wt,
                                       input int ht, input int len);
        t_in_item op;
        op.func          = f;
        op.index         = 14'(idx);
        op.pixel         = 8'(pix);
        op.pos_x         = 16'(px);
        op.pos_y         = 16'(py);
        op.width_tiles   = 3'(wt);
        op.height_tiles  = 3'(ht);
        op.sprite_length = 11'(len);
        return op;
    endfunction

    function automatic t_in_item random_op(input logic [1:0] f);
        logic [IN_BITS-1:0] raw;
        t_in_item op;
        raw = IN_BITS'({$urandom, $urandom, $urandom});
        op = raw;
        op.func = f;
        return op;
    endfunction

    // screen offset to world position, held inside the 16-bit range
    function automatic logic signed [15:0] to_world(input int screen_pos, input int cam);
        int w;
        w = screen_pos + cam;
        if (w > 32767) w = 32767;
        if (w < -32768) w = -32768;
        return 16'(w);
    endfunction

    task automatic add_row(input t_in_item op, input int want);
        t_dir_row row;
        row.op   = op;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    // present one beat, hold it until taken, then record what it owes
    task automatic send_item(input t_in_item op, input int want);
        int gap;
        t_out_item due;
        gap = (!quiet && $urandom_range(99) < IDLE_PCT) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= op;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        due = predict_op(op);
        if (want != NO_WANT) due.read_pixel = 8'(want);
        due_beats.push_back(due);
        op_count[op.func]++;
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
    endtask

    // write both camera registers and read them back
    task automatic set_camera(input int cx, input int cy);
        logic [31:0] rd;
        int want [2];
        logic [2:0] addr [2];
        want[0] = cx;
        want[1] = cy;
        addr[0] = CAM_X_ADDR;
        addr[1] = CAM_Y_ADDR;
        for (int r = 0; r < 2; r++) apb_access(1'b1, addr[r], 32'(want[r]), rd);
        for (int r = 0; r < 2; r++) begin
            apb_access(1'b0, addr[r], 32'd0, rd);
            if (rd[15:0] !== 16'(want[r]))
                report_mismatch($sformatf("camera reg at %0d reads %h, wrote %h",
                                          addr[r], rd[15:0], 16'(want[r])));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cam_x = cx;
        cam_y = cy;
    endtask

    // a draw, well placed or fully random, then reads around its footprint
    task automatic plan_draw(input bit noisy);
        t_in_item op;
        int wt, ht, pw, ph, len, ox, oy, pick, x0, y0, n, x, y;
        op = random_op(FUNC_DRAW);
        if (!noisy) begin
            wt = ($urandom_range(9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, MAX_TILES);
            ht = ($urandom_range(9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, MAX_TILES);
            op.width_tiles  = 3'(wt);
            op.height_tiles = 3'(ht);
            pw = ((wt > MAX_TILES) ? MAX_TILES : wt) * TILE_PIXELS;
            ph = ((ht > MAX_TILES) ? MAX_TILES : ht) * TILE_PIXELS;
            pick = $urandom_range(9);
            if (pick < 5) len = (sprite_prefix < pw * ph) ? sprite_prefix : pw * ph;
            else if (pick < 8) len = $urandom_range(0, sprite_prefix);
            else len = $urandom_range(0, 2047);
            op.sprite_length = 11'(len);
            pick = $urandom_range(9);
            if (pick < 6) begin
                ox = int'($urandom_range(0, SCREEN_W + 40)) - 40;
                oy = int'($urandom_range(0, SCREEN_H + 40)) - 40;
            end else begin
                // straddling an edge
                ox = $urandom_range(1) ? -int'($urandom_range(0, pw))
                                       : SCREEN_W - int'($urandom_range(0, pw));
                oy = $urandom_range(1) ? -int'($urandom_range(0, ph))
                                       : SCREEN_H - int'($urandom_range(0, ph));
            end
            if (pick < 9) begin
                op.pos_x = to_world(ox, cam_x);
                op.pos_y = to_world(oy, cam_y);
            end
        end
        // keep every sprite read inside the loaded prefix
        if (walk_draw(op, 1'b0)) op.sprite_length = 11'($urandom_range(0, sprite_prefix));
        op_plan.push_back(op);

        pw = ((op.width_tiles > MAX_TILES) ? MAX_TILES : int'(op.width_tiles)) * TILE_PIXELS;
        ph = ((op.height_tiles > MAX_TILES) ? MAX_TILES : int'(op.height_tiles)) * TILE_PIXELS;
        x0 = int'($signed(op.pos_x)) - cam_x;
        y0 = int'($signed(op.pos_y)) - cam_y;
        n  = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
            x = x0 + int'($urandom_range(0, (pw > 0) ? pw - 1 : 0));
            y = y0 + int'($urandom_range(0, (ph > 0) ? ph - 1 : 0));
            op = random_op(FUNC_READ);
            if (x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H)
                op.index = 14'(y * SCREEN_W + x);
            op_plan.push_back(op);
        end
    endtask

    task automatic plan_sequence();
        t_in_item op;
        int pick, n, start;
        pick = $urandom_range(99);
        if (pick < 35) begin
            // run of sprite pixels, mostly growing the loaded prefix
            n = $urandom_range(4, 24);
            start = ($urandom_range(9) < 7) ? sprite_prefix : $urandom_range(0, sprite_prefix);
            for (int k = 0; k < n; k++) begin
                op = random_op(FUNC_LOAD);
                op.index = 14'(start + k);
                op.pixel = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                op_plan.push_back(op);
            end
        end else if (pick < 40) begin
            // stray loads anywhere in the index space
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) op_plan.push_back(random_op(FUNC_LOAD));
        end else if (pick < 70) begin
            plan_draw(1'b0);
        end else if (pick < 75) begin
            plan_draw(1'b1);
        end else if (pick < 77 && clears_left > 0) begin
            clears_left--;
            op_plan.push_back(random_op(FUNC_CLEAR));
            op_plan.push_back(random_op(FUNC_READ));
        end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) op_plan.push_back(random_op(FUNC_READ));
        end
    endtask

    // result side: random stall, compare each taken beat with the oldest one owed
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (due_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat %h", o_out_data));
                end else begin
                    want = due_beats.pop_front();
                    if (o_out_data.read_pixel !== want.read_pixel)
                        report_mismatch($sformatf("read_pixel %h, want %h (func %0d)",
                                                  o_out_data.read_pixel, want.read_pixel,
                                                  want.done_func));
                    if (o_out_data.done_func !== want.done_func)
                        report_mismatch($sformatf("done_func %0d, want %0d",
                                                  o_out_data.done_func, want.done_func));
                end
            end
            i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // stimulus
    initial begin
        int phase_cx [NUM_PHASES];
        int phase_cy [NUM_PHASES];
        int sent_here;

        // directed rows under the reset camera
        add_row(mk_op(FUNC_READ,  0, 0, 0, 0, 0, 0, 0), 0);
        add_row(mk_op(FUNC_READ,  FRAME_PIXELS - 1, 0, 0, 0, 0, 0, 0), 0);
        add_row(mk_op(FUNC_LOAD,  0, 255, 0, 0, 0, 0, 0), 0);
        add_row(mk_op(FUNC_LOAD,  1, 0, 0, 0, 0, 0, 0), 0);
        add_row(mk_op(FUNC_LOAD,  2, 1, 0, 0, 0, 0, 0), 0);
        add_row(mk_op(FUNC_LOAD,  3, 8'h80, 0, 0, 0, 0, 0), 0);
        add_row(mk_op(FUNC_LOAD,  16383, 8'haa, 0, 0, 0, 0, 0), 0);
        add_row(mk_op(FUNC_LOAD,  SPRITE_DEPTH - 1, 8'h55, 0, 0, 0, 0, 0), 0);
        add_row(mk_op(FUNC_DRAW,  0, 0, 0, 0, 1, 1, 4), 0);
        add_row(mk_op(FUNC_READ,  0, 0, 0, 0, 0, 0, 0), 255);
        add_row(mk_op(FUNC_READ,  1, 0, 0, 0, 0, 0, 0), 0);
        add_row(mk_op(FUNC_READ,  3, 0, 0, 0, 0, 0, 0), NO_WANT);
        add_row(mk_op(FUNC_DRAW,  0, 0, 126, 0, 1, 1, 4), 0);
        add_row(mk_op(FUNC_READ,  126, 0, 0, 0, 0, 0, 0), NO_WANT);
        add_row(mk_op(FUNC_READ,  128, 0, 0, 0, 0, 0, 0), NO_WANT);
        add_row(mk_op(FUNC_DRAW,  0, 0, -2, 127, 1, 1, 4), 0);
        add_row(mk_op(FUNC_READ,  127 * SCREEN_W, 0, 0, 0, 0, 0, 0), NO_WANT);
        add_row(mk_op(FUNC_DRAW,  0, 0, -32768, -32768, 7, 7, 2047), 0);
        add_row(mk_op(FUNC_DRAW,  0, 0, 32767, 32767, 0, 0, 0), 0);
        add_row(mk_op(FUNC_DRAW,  0, 0, 10, 10, 0, 1, 4), 0);
        add_row(mk_op(FUNC_DRAW,  0, 0, 20, 20, 4, 4, 0), 0);
        add_row(mk_op(FUNC_DRAW,  0, 0, 0, 5, 5, 1, 4), 0);
        add_row(mk_op(FUNC_READ,  5 * SCREEN_W + 2, 0, 0, 0, 0, 0, 0), NO_WANT);
        add_row(mk_op(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0);
        add_row(mk_op(FUNC_READ,  0, 0, 0, 0, 0, 0, 0), 0);

        // camera per random phase: both extremes, reset value, near and anywhere
        phase_cx[0] = -32768;  phase_cy[0] = 32767;
        phase_cx[1] = 32767;   phase_cy[1] = -32768;
        phase_cx[2] = 0;       phase_cy[2] = 0;
        phase_cx[3] = int'($urandom_range(0, 128)) - 64;
        phase_cy[3] = int'($urandom_range(0, 128)) - 64;
        phase_cx[4] = int'($urandom_range(0, 65535)) - 32768;
        phase_cy[4] = int'($urandom_range(0, 65535)) - 32768;

        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_item(dir_rows[i].op, dir_rows[i].want);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // sender holds off until every owed beat is back
            i_in_valid <= 1'b0;
            while (due_beats.size() != 0) @(posedge i_clk);
            set_camera(phase_cx[p], phase_cy[p]);
            quiet = (p == 2);
            sent_here = 0;
            while (sent_here < PHASE_OPS || op_plan.size() != 0) begin
                if (op_plan.size() == 0) plan_sequence();
                send_item(op_plan.pop_front(), NO_WANT);
                sent_here++;
            end
        end
        i_in_valid <= 1'b0;
        quiet = 1'b0;

        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d clears, %0d loads, %0d draws, %0d reads over %0d camera settings",
                 op_count[FUNC_CLEAR], op_count[FUNC_LOAD], op_count[FUNC_DRAW],
                 op_count[FUNC_READ], NUM_PHASES + 1);
        $display("tb: loaded sprite prefix reached %0d entries, %0d mismatches",
                 sprite_prefix, mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/sbcc_pkg.sv
rtl/sbcc_alu.sv
rtl/sprite_blitter_clip_colorkey.sv
tb/sv/testbench.sv
